/* hdl/sbst_pkg.sv */
// Package for the segment versus box slab test.
// Holds the field widths and the structs passed between pipeline stages.
// No dependencies.
`default_nettype none

package sbst_pkg;

	localparam int COORD_WIDTH = 24;
	localparam int SIZE_WIDTH  = COORD_WIDTH - 1;
	localparam int NUM_WIDTH   = COORD_WIDTH + 3;
	localparam int DEN_WIDTH   = COORD_WIDTH + 1;
	localparam int PROD_WIDTH  = NUM_WIDTH + DEN_WIDTH + 1;

	typedef struct packed {
		logic signed [NUM_WIDTH-1:0] n_in;
		logic signed [NUM_WIDTH-1:0] n_out;
		logic [DEN_WIDTH-1:0]        den;
		logic                        dz;
		logic                        slab_ok;
	} axis_t;

	typedef struct packed {
		logic signed [PROD_WIDTH-1:0] in_x_dy;
		logic signed [PROD_WIDTH-1:0] out_y_dx;
		logic signed [PROD_WIDTH-1:0] in_y_dx;
		logic signed [PROD_WIDTH-1:0] out_x_dy;
		logic                         simple_ok;
		logic                         both_moving;
	} cross_t;

endpackage

`default_nettype wire

/* hdl/sbst_axis_prep.sv */
// One axis of the slab test: entry and exit numerators over a shared denominator.
// Works in doubled units so half sizes are exact. Uses sbst_pkg.
`default_nettype none

module sbst_axis_prep (
	input  wire logic signed [sbst_pkg::COORD_WIDTH-1:0] center,
	input  wire logic [sbst_pkg::SIZE_WIDTH-1:0]         size,
	input  wire logic signed [sbst_pkg::COORD_WIDTH-1:0] origin,
	input  wire logic signed [sbst_pkg::COORD_WIDTH-1:0] delta,
	output sbst_pkg::axis_t                               axis
);
	import sbst_pkg::*;

	logic signed [NUM_WIDTH-1:0]   c2;
	logic signed [NUM_WIDTH-1:0]   sz;
	logic signed [NUM_WIDTH-1:0]   o2;
	logic signed [NUM_WIDTH-1:0]   lo2;
	logic signed [NUM_WIDTH-1:0]   hi2;
	logic signed [COORD_WIDTH:0]   d_ext;
	logic signed [COORD_WIDTH:0]   d_abs;
	logic                          neg;

	always_comb begin
		c2    = {{2{center[COORD_WIDTH-1]}}, center, 1'b0};
		sz    = {4'b0000, size};
		o2    = {{2{origin[COORD_WIDTH-1]}}, origin, 1'b0};
		lo2   = c2 - sz;
		hi2   = c2 + sz;
		neg   = delta[COORD_WIDTH-1];
		d_ext = {delta[COORD_WIDTH-1], delta};
		d_abs = neg ? -d_ext : d_ext;

		axis.den     = {d_abs[COORD_WIDTH-1:0], 1'b0};
		axis.dz      = (delta == '0);
		axis.slab_ok = (o2 >= lo2) && (o2 <= hi2);
		if (neg) begin
			axis.n_in  = o2 - hi2;
			axis.n_out = o2 - lo2;
		end else begin
			axis.n_in  = lo2 - o2;
			axis.n_out = hi2 - o2;
		end
	end

endmodule

`default_nettype wire

/* hdl/sbst_cross.sv */
// Cross products between the two axes and the checks against the range [0, 1].
// Takes the registered axis results of both axes. Uses sbst_pkg.
`default_nettype none

module sbst_cross (
	input  wire sbst_pkg::axis_t ax,
	input  wire sbst_pkg::axis_t ay,
	output sbst_pkg::cross_t     cr
);
	import sbst_pkg::*;

	logic ok_x;
	logic ok_y;

	always_comb begin
		ok_x = ax.dz ? ax.slab_ok
			: (!ax.n_out[NUM_WIDTH-1] && ($signed(ax.n_in) <= $signed({2'b00, ax.den})));
		ok_y = ay.dz ? ay.slab_ok
			: (!ay.n_out[NUM_WIDTH-1] && ($signed(ay.n_in) <= $signed({2'b00, ay.den})));

		cr.in_x_dy     = $signed(ax.n_in) * $signed({1'b0, ay.den});
		cr.out_y_dx    = $signed(ay.n_out) * $signed({1'b0, ax.den});
		cr.in_y_dx     = $signed(ay.n_in) * $signed({1'b0, ax.den});
		cr.out_x_dy    = $signed(ax.n_out) * $signed({1'b0, ay.den});
		cr.simple_ok   = ok_x && ok_y;
		cr.both_moving = !ax.dz && !ay.dz;
	end

endmodule

`default_nettype wire

/* hdl/segment_box_slab_test.sv */
// Top level of the segment versus axis-aligned box slab test.
// Instantiates sbst_axis_prep twice and sbst_cross; uses sbst_pkg.
//
//   Channel  Handshake            Payload
//   in       in_valid, in_stall   box_center_x/y, box_width/height, seg_origin_x/y, seg_delta_x/y
//   out      out_valid, out_stall hit
//
// One item enters per cycle while in_stall is low, and each item is registered at every stage.
// Stage one forms the slab numerators, stage two the four cross products, stage three
// the final compares into the output register.
// Reset clears only the stage valid bits. A stall on the output holds the result, and
// empty stages still fill, so input is refused only when every stage holds an item.
`default_nettype none

module segment_box_slab_test (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   in_valid,
	output logic                                        in_stall,
	input  wire logic signed [sbst_pkg::COORD_WIDTH-1:0] box_center_x,
	input  wire logic signed [sbst_pkg::COORD_WIDTH-1:0] box_center_y,
	input  wire logic [sbst_pkg::SIZE_WIDTH-1:0]        box_width,
	input  wire logic [sbst_pkg::SIZE_WIDTH-1:0]        box_height,
	input  wire logic signed [sbst_pkg::COORD_WIDTH-1:0] seg_origin_x,
	input  wire logic signed [sbst_pkg::COORD_WIDTH-1:0] seg_origin_y,
	input  wire logic signed [sbst_pkg::COORD_WIDTH-1:0] seg_delta_x,
	input  wire logic signed [sbst_pkg::COORD_WIDTH-1:0] seg_delta_y,
	output logic                                        out_valid,
	input  wire logic                                   out_stall,
	output logic                                        hit
);
	import sbst_pkg::*;

	axis_t  ax_c;
	axis_t  ay_c;
	axis_t  ax_s1;
	axis_t  ay_s1;
	cross_t cr_c;
	cross_t cr_s2;
	logic   v_s1;
	logic   v_s2;
	logic   v_s3;
	logic   hit_s3;
	logic   hit_c;
	logic   en1;
	logic   en2;
	logic   en3;

	sbst_axis_prep u_prep_x (
		.center (box_center_x),
		.size   (box_width),
		.origin (seg_origin_x),
		.delta  (seg_delta_x),
		.axis   (ax_c)
	);

	sbst_axis_prep u_prep_y (
		.center (box_center_y),
		.size   (box_height),
		.origin (seg_origin_y),
		.delta  (seg_delta_y),
		.axis   (ay_c)
	);

	sbst_cross u_cross (
		.ax (ax_s1),
		.ay (ay_s1),
		.cr (cr_c)
	);

	always_comb begin
		en3      = !v_s3 || !out_stall;
		en2      = !v_s2 || en3;
		en1      = !v_s1 || en2;
		in_stall = !en1;
		hit_c    = cr_s2.simple_ok && (!cr_s2.both_moving ||
			((cr_s2.in_x_dy <= cr_s2.out_y_dx) && (cr_s2.in_y_dx <= cr_s2.out_x_dy)));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) begin
				v_s1 <= in_valid;
			end
			if (en2) begin
				v_s2 <= v_s1;
			end
			if (en3) begin
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			ax_s1 <= ax_c;
			ay_s1 <= ay_c;
		end
		if (en2) begin
			cr_s2 <= cr_c;
		end
		if (en3) begin
			hit_s3 <= hit_c;
		end
	end

	assign out_valid = v_s3;
	assign hit       = hit_s3;

endmodule

`default_nettype wire

/* hdl/sbst_checker.sv */
// Port-level checks for segment_box_slab_test, attached to it by a bind statement.
// Sees only the top-level ports. Uses sbst_pkg for the field widths.
`default_nettype none

module sbst_checker (
	input wire logic                                   clk,
	input wire logic                                   arst_n,
	input wire logic                                   in_valid,
	input wire logic                                   in_stall,
	input wire logic signed [sbst_pkg::COORD_WIDTH-1:0] box_center_x,
	input wire logic                                   out_valid,
	input wire logic                                   out_stall,
	input wire logic                                   hit
);
	import sbst_pkg::*;

	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(box_center_x))
		else $error("A stalled input item changed or vanished.");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(hit))
		else $error("A stalled result item changed or vanished.");

	assert property (@(posedge clk) disable iff (!arst_n)
		!out_stall |-> !in_stall)
		else $error("Input was refused while the output was free.");

	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) ##1 !out_stall ##1 !out_stall |=> out_valid)
		else $error("An item did not reach the output after three free cycles.");

	assert property (@(posedge clk) disable iff (!arst_n)
		(!in_valid && !out_stall) ##1 (!in_valid && !out_stall) ##1
		(!in_valid && !out_stall) |=> !out_valid)
		else $error("A result item appeared without an input item.");

endmodule

bind segment_box_slab_test sbst_checker u_sbst_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.box_center_x (box_center_x),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.hit          (hit)
);

`default_nettype wire
